// File: design/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor package
// Shared payload types, command and status structs, and constants.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int unsigned WINDOW_BYTES_DEF = 4096;
	localparam int unsigned START_GAP = 18;
	localparam int unsigned MATCH_LEN_BIAS = 3;
	localparam int unsigned CNT_W = 24;
	localparam int unsigned LEN_W = 5;
	localparam int unsigned FLAG_BITS = 8;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} lzwd_in_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             data_valid;
		logic             run_last;
		logic             stream_done;
		logic [CNT_W-1:0] total_count;
	} lzwd_out_t;

	typedef struct packed {
		logic load;
		logic from_mem;
		logic data_valid;
		logic run_last;
		logic stream_done;
		logic rd_issue;
		logic clear;
	} lzwd_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] produced_count;
		logic             slot_free;
	} lzwd_stat_t;

endpackage

// File: design/lzwd_dpath.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor datapath
// History window memory, write position, fill count, byte counter and the
// result register.
// ----------------------------------------------------------------------------
module lzwd_dpath
	import lzwd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lzwd_cmd_t                       cmd,
	input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
	input  logic [7:0]                      lit_byte,
	input  logic                            dec_stall,
	output logic                            dec_valid,
	output lzwd_out_t                       dec_req,
	output lzwd_stat_t                      stat
);

	localparam int unsigned AW = $clog2(WINDOW_BYTES);
	localparam logic [AW-1:0] START_POS = AW'(WINDOW_BYTES - START_GAP);
	localparam logic [AW:0] FILL_FULL = (AW+1)'(WINDOW_BYTES);

	logic [7:0]       mem [WINDOW_BYTES];
	logic [AW-1:0]    wp_q;
	logic [AW:0]      fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rd_mem_q;
	logic [7:0]       fwd_byte_q;
	logic             fwd_q;
	logic             rd_ok_q;
	logic             out_valid_q;
	lzwd_out_t        out_q;

	logic             wr_en;
	logic             fwd_hit;
	logic [AW-1:0]    rd_rel;
	logic             rd_written;
	logic [7:0]       mem_byte;
	logic [7:0]       emit_byte;
	logic [7:0]       res_byte;
	logic [CNT_W-1:0] cnt_inc;

	assign wr_en      = cmd.load && cmd.data_valid;
	assign fwd_hit    = wr_en && (wp_q == rd_addr);
	assign rd_rel     = rd_addr - START_POS;
	assign rd_written = {1'b0, rd_rel} < fill_q;
	assign mem_byte   = rd_ok_q ? (fwd_q ? fwd_byte_q : rd_mem_q) : 8'd0;
	assign emit_byte  = cmd.from_mem ? mem_byte : lit_byte;
	assign res_byte   = cmd.data_valid ? emit_byte : 8'd0;
	assign cnt_inc    = cnt_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= emit_byte;
		end
		if (cmd.rd_issue) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			fwd_q      <= fwd_hit;
			fwd_byte_q <= emit_byte;
			rd_ok_q    <= fwd_hit || rd_written;
		end
		if (cmd.load) begin
			out_q.out_byte    <= res_byte;
			out_q.data_valid  <= cmd.data_valid;
			out_q.run_last    <= cmd.run_last;
			out_q.stream_done <= cmd.stream_done;
			out_q.total_count <= wr_en ? cnt_inc : cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= START_POS;
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				wp_q   <= START_POS;
				fill_q <= '0;
				cnt_q  <= '0;
			end else if (wr_en) begin
				wp_q   <= wp_q + AW'(1);
				fill_q <= (fill_q == FILL_FULL) ? fill_q : fill_q + (AW+1)'(1);
				cnt_q  <= cnt_inc;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!dec_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dec_valid           = out_valid_q;
	assign dec_req             = out_q;
	assign stat.produced_count = cnt_q;
	assign stat.slot_free      = !out_valid_q || !dec_stall;

endmodule

// File: design/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor controller
// Token parser, output limit tracking and match copy sequencer.
// ----------------------------------------------------------------------------
module lzwd_ctrl
	import lzwd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmp_valid,
	output logic                            cmp_stall,
	input  lzwd_in_t                        cmp_req,
	input  logic                            cfg_we,
	input  logic [CNT_W-1:0]                cfg_wdata,
	input  lzwd_stat_t                      stat,
	output lzwd_cmd_t                       cmd,
	output logic [$clog2(WINDOW_BYTES)-1:0] rd_addr
);

	localparam int unsigned AW = $clog2(WINDOW_BYTES);

	typedef enum logic {S_IDLE, S_COPY} state_t;
	typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_MLO, PH_MHI} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] shift;
		logic [3:0] left;
	} tok_t;

	function automatic tok_t next_token(input logic [7:0] shift, input logic [3:0] left);
		tok_t t;
		t.shift = shift >> 1;
		t.left  = (left != 4'd0) ? left - 4'd1 : left;
		if (t.left == 4'd0) begin
			t.phase = PH_FLAG;
		end else begin
			t.phase = t.shift[0] ? PH_LIT : PH_MLO;
		end
		return t;
	endfunction

	state_t           state_q;
	phase_t           phase_q;
	logic [7:0]       shift_q;
	logic [3:0]       left_q;
	logic [7:0]       mlo_q;
	logic             lim_q;
	logic             last_q;
	logic [CNT_W-1:0] limit_q;
	logic [AW-1:0]    copy_addr_q;
	logic [LEN_W-1:0] issue_left_q;
	logic [LEN_W-1:0] emit_left_q;
	logic             rd_pend_q;

	logic             accept;
	logic             lim_now;
	logic             hit_next;
	logic [AW-1:0]    match_off;
	logic [LEN_W-1:0] match_len;
	logic [CNT_W-1:0] room;
	logic [LEN_W-1:0] copy_n;
	logic             emit_now;
	logic             issue;
	logic             final_emit;
	tok_t             tok_nx;

	assign accept     = cmp_valid && (state_q == S_IDLE) && stat.slot_free;
	assign cmp_stall  = !((state_q == S_IDLE) && stat.slot_free);
	assign lim_now    = lim_q || (stat.produced_count >= limit_q);
	assign hit_next   = ({1'b0, stat.produced_count} + (CNT_W+1)'(1)) >= {1'b0, limit_q};
	assign match_off  = AW'({cmp_req.in_byte[7:4], mlo_q});
	assign match_len  = LEN_W'(cmp_req.in_byte[3:0]) + LEN_W'(MATCH_LEN_BIAS);
	assign room       = limit_q - stat.produced_count;
	assign copy_n     = (room < CNT_W'(match_len)) ? room[LEN_W-1:0] : match_len;
	assign emit_now   = (state_q == S_COPY) && rd_pend_q && stat.slot_free;
	assign issue      = (state_q == S_COPY) && (issue_left_q != '0) && (!rd_pend_q || emit_now);
	assign final_emit = emit_now && (emit_left_q == LEN_W'(1));
	assign tok_nx     = next_token(shift_q, left_q);
	assign rd_addr    = (state_q == S_IDLE) ? match_off : copy_addr_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!lim_now && (phase_q == PH_LIT)) begin
						cmd.load        = 1'b1;
						cmd.data_valid  = 1'b1;
						cmd.run_last    = 1'b1;
						cmd.stream_done = cmp_req.in_last;
						cmd.clear       = cmp_req.in_last;
					end else if (!lim_now && (phase_q == PH_MHI)) begin
						cmd.rd_issue = 1'b1;
					end else if (cmp_req.in_last) begin
						cmd.load        = 1'b1;
						cmd.run_last    = 1'b1;
						cmd.stream_done = 1'b1;
						cmd.clear       = 1'b1;
					end
				end
			end
			S_COPY: begin
				cmd.rd_issue = issue;
				if (emit_now) begin
					cmd.load        = 1'b1;
					cmd.from_mem    = 1'b1;
					cmd.data_valid  = 1'b1;
					cmd.run_last    = final_emit;
					cmd.stream_done = final_emit && last_q;
					cmd.clear       = final_emit && last_q;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_FLAG;
			shift_q      <= '0;
			left_q       <= '0;
			mlo_q        <= '0;
			lim_q        <= 1'b0;
			last_q       <= 1'b0;
			limit_q      <= LIMIT_RESET;
			copy_addr_q  <= '0;
			issue_left_q <= '0;
			emit_left_q  <= '0;
			rd_pend_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= cmp_req.in_last;
						if (lim_now) begin
							lim_q <= 1'b1;
						end else begin
							unique case (phase_q)
								PH_FLAG: begin
									shift_q <= cmp_req.in_byte;
									left_q  <= 4'(FLAG_BITS);
									phase_q <= cmp_req.in_byte[0] ? PH_LIT : PH_MLO;
								end
								PH_LIT: begin
									lim_q   <= hit_next;
									phase_q <= tok_nx.phase;
									shift_q <= tok_nx.shift;
									left_q  <= tok_nx.left;
								end
								PH_MLO: begin
									mlo_q   <= cmp_req.in_byte;
									phase_q <= PH_MHI;
								end
								PH_MHI: begin
									state_q      <= S_COPY;
									copy_addr_q  <= match_off + AW'(1);
									issue_left_q <= copy_n - LEN_W'(1);
									emit_left_q  <= copy_n;
									rd_pend_q    <= 1'b1;
								end
								default: begin
									phase_q <= PH_FLAG;
								end
							endcase
						end
						if (cmp_req.in_last && !(!lim_now && (phase_q == PH_MHI))) begin
							phase_q <= PH_FLAG;
							shift_q <= '0;
							left_q  <= '0;
							mlo_q   <= '0;
							lim_q   <= 1'b0;
						end
					end
				end
				S_COPY: begin
					if (issue) begin
						copy_addr_q  <= copy_addr_q + AW'(1);
						issue_left_q <= issue_left_q - LEN_W'(1);
						rd_pend_q    <= 1'b1;
					end else if (emit_now) begin
						rd_pend_q <= 1'b0;
					end
					if (emit_now) begin
						emit_left_q <= emit_left_q - LEN_W'(1);
						if (hit_next) begin
							lim_q <= 1'b1;
						end
					end
					if (final_emit) begin
						state_q <= S_IDLE;
						if (last_q) begin
							phase_q <= PH_FLAG;
							shift_q <= '0;
							left_q  <= '0;
							mlo_q   <= '0;
							lim_q   <= 1'b0;
						end else begin
							phase_q <= tok_nx.phase;
							shift_q <= tok_nx.shift;
							left_q  <= tok_nx.left;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/lzss_window_decompressor_top.sv
// A literal or end-of-stream result is registered in the cycle after its byte is taken.
// A match reads its first byte into a read register after the high byte, loads it into the
// output register, then emits one byte per cycle while the output is not stalled. Input is
// stalled during a match copy; otherwise a new byte is taken while the last result drains.
// Reset clears all control state and sets the output limit to 0xFFFFFF; the window reads as
// zero through a fill count, so there is no clearing pass.
// ----------------------------------------------------------------------------
// LZSS window decompressor top level
// Decodes an LZSS byte stream with a WINDOW_BYTES history window (4096 bytes by default).
// ----------------------------------------------------------------------------
module lzss_window_decompressor_top
	import lzwd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmp_valid,
	output logic             cmp_stall,
	input  lzwd_in_t         cmp_req,
	output logic             dec_valid,
	input  logic             dec_stall,
	output lzwd_out_t        dec_req,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(WINDOW_BYTES);

	lzwd_cmd_t     cmd;
	lzwd_stat_t    stat;
	logic [AW-1:0] rd_addr;

	lzwd_ctrl #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmp_valid(cmp_valid),
		.cmp_stall(cmp_stall),
		.cmp_req  (cmp_req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	lzwd_dpath #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.lit_byte (cmp_req.in_byte),
		.dec_stall(dec_stall),
		.dec_valid(dec_valid),
		.dec_req  (dec_req),
		.stat     (stat)
	);

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_valid && !cmp_stall) |-> !(dec_valid && dec_stall))
		else $error("request taken while the result register is blocked");

	a_done_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_valid && dec_req.stream_done) |-> dec_req.run_last)
		else $error("stream end without run end");

	a_empty_result_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_valid && !dec_req.data_valid) |-> (dec_req.stream_done && dec_req.out_byte == 8'd0))
		else $error("empty result that does not end the stream");

	a_clear_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.stream_done) |=> (stat.produced_count == '0))
		else $error("byte count not cleared after stream end");

endmodule
